>>> rtl/tcse_pkg.sv
// ----------------------------------------------------------------------------
// tcse_pkg
// Shared types and constants of the teaching CPU slice executor.
// ----------------------------------------------------------------------------
`default_nettype none
package tcse_pkg;
   localparam int MemWords = 4096;
   localparam int MemAw    = $clog2(MemWords);
   localparam int NumRegs  = 8;
   localparam int RegAw    = $clog2(NumRegs);

   // request kinds
   localparam logic [2:0] KIND_WMEM = 3'd0;
   localparam logic [2:0] KIND_RMEM = 3'd1;
   localparam logic [2:0] KIND_WREG = 3'd2;
   localparam logic [2:0] KIND_RREG = 3'd3;
   localparam logic [2:0] KIND_RUN  = 3'd4;

   // register selectors
   localparam logic [3:0] RIDX_PC  = 4'd8;
   localparam logic [3:0] RIDX_ACC = 4'd9;

   // interrupt codes
   localparam logic [2:0] CODE_NONE  = 3'd0;
   localparam logic [2:0] CODE_CLOCK = 3'd1;
   localparam logic [2:0] CODE_HALT  = 3'd2;
   localparam logic [2:0] CODE_SYSC  = 3'd3;
   localparam logic [2:0] CODE_SEGV  = 3'd4;
   localparam logic [2:0] CODE_ILL   = 3'd5;

   // opcodes
   localparam logic [7:0] OP_ADD   = 8'd0;
   localparam logic [7:0] OP_SUB   = 8'd1;
   localparam logic [7:0] OP_CMP   = 8'd2;
   localparam logic [7:0] OP_IFGT  = 8'd3;
   localparam logic [7:0] OP_NOP   = 8'd4;
   localparam logic [7:0] OP_JUMP  = 8'd5;
   localparam logic [7:0] OP_HALT  = 8'd6;
   localparam logic [7:0] OP_SYSC  = 8'd7;
   localparam logic [7:0] OP_LOAD  = 8'd8;
   localparam logic [7:0] OP_STORE = 8'd9;

   // config register indexes
   localparam logic [1:0] CSR_BASE    = 2'd0;
   localparam logic [1:0] CSR_SIZE    = 2'd1;
   localparam logic [1:0] CSR_QUANTUM = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic       take_req;   // latch request fields
      logic       do_simple;  // perform memory/register request
      logic       slice_init; // clear slice counter
      logic       fetch;      // check pc, read instruction memory
      logic       exec;       // execute fetched word
      logic       mem_fin;    // finish load/store
      logic       finish;     // capture response
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic       is_run;
      logic       quantum_done;
      logic       fetch_fault;
      logic       need_mem;   // instruction is an in-segment load or store
      logic       stop;       // instruction ends slice
      logic [2:0] stop_code;
   } stat_type;
endpackage
`default_nettype wire

>>> rtl/tcse_ctrl.sv
// ----------------------------------------------------------------------------
// tcse_ctrl
// Sequencer: request intake, fetch/execute/memory steps, response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module tcse_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              rsp_busy,   // output register still full
   output tcse_pkg::ctrl_type     ctrl,
   input  wire tcse_pkg::stat_type stat,
   output logic [2:0]             code
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DEC   = 7'b0000010,
      ST_FETCH = 7'b0000100,
      ST_WAIT  = 7'b0001000,
      ST_EXEC  = 7'b0010000,
      ST_MEM   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] code_ff, code_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign code      = code_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.take_req = 1'b1;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            code_in = tcse_pkg::CODE_NONE;
            if (stat.is_run) begin
               ctrl.slice_init = 1'b1;
               state_in = ST_FETCH;
            end else begin
               ctrl.do_simple = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_FETCH: begin
            if (stat.quantum_done) begin
               code_in  = tcse_pkg::CODE_CLOCK;
               state_in = ST_DONE;
            end else if (stat.fetch_fault) begin
               code_in  = tcse_pkg::CODE_SEGV;
               state_in = ST_DONE;
            end else begin
               ctrl.fetch = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctrl.exec = 1'b1;
            if (stat.stop) begin
               code_in  = stat.stop_code;
               state_in = ST_DONE;
            end else if (stat.need_mem) begin
               state_in = ST_MEM;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_MEM: begin
            ctrl.mem_fin = 1'b1;
            state_in = ST_FETCH;
         end
         // memory read data lands in the cycle after do_simple
         ST_WAIT: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_busy) begin
               ctrl.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         code_ff  <= tcse_pkg::CODE_NONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/tcse_datapath.sv
// ----------------------------------------------------------------------------
// tcse_datapath
// Memory, register file, PC, accumulator, config registers and ALU.
// ----------------------------------------------------------------------------
`default_nettype none
module tcse_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tcse_pkg::ctrl_type ctrl,
   output tcse_pkg::stat_type     stat,
   input  wire logic [2:0]        req_kind,
   input  wire logic [11:0]       req_address,
   input  wire logic [3:0]        req_reg_index,
   input  wire logic [31:0]       req_data,
   input  wire logic              cfg_we,
   input  wire logic [1:0]        cfg_idx,
   input  wire logic [31:0]       cfg_wdata,
   output logic [31:0]            cfg_rdata,
   output logic [31:0]            read_data,
   output logic [31:0]            pc_value,
   output logic [31:0]            acc_value
);
   localparam int Aw = tcse_pkg::MemAw;
   localparam int Rw = tcse_pkg::RegAw;

   logic [31:0] mem [tcse_pkg::MemWords];
   logic [31:0] mem_q;

   logic [31:0] regs_ff [tcse_pkg::NumRegs];
   logic [31:0] pc_ff, acc_ff;
   logic [7:0]  cnt_ff;
   logic [11:0] base_ff;
   logic [12:0] size_ff;
   logic [7:0]  quant_ff;
   logic [2:0]  kind_ff;
   logic [11:0] addr_ff;
   logic [3:0]  ridx_ff;
   logic [31:0] data_ff;
   logic [31:0] rd_ff;
   logic        rd_mem_ff;   // read data comes from memory
   logic [Rw-1:0] ldi_ff;
   logic        ldv_ff;      // pending load completes in the memory step
   logic        ldok_ff;     // load target is a real register

   // instruction fields
   logic [7:0]  op;
   logic [2:0]  ri, rj;
   logic [31:0] arg, vi, vj, sum, off, diff;
   logic        ri_ok, rj_ok, off_ok, pc_ok;
   logic [Aw-1:0] phys_pc, phys_off;

   assign op    = mem_q[31:24];
   assign ri    = mem_q[22:20];
   assign rj    = mem_q[18:16];
   assign arg   = {{16{mem_q[15]}}, mem_q[15:0]};
   assign ri_ok = ({1'b0, ri} < 4'(tcse_pkg::NumRegs));
   assign rj_ok = ({1'b0, rj} < 4'(tcse_pkg::NumRegs));
   assign vi    = ri_ok ? regs_ff[ri[Rw-1:0]] : 32'd0;
   assign vj    = rj_ok ? regs_ff[rj[Rw-1:0]] : 32'd0;
   assign off   = vj + arg;
   assign sum   = vi + off;
   assign diff  = vi - off;
   assign off_ok = !off[31] && (off < {19'd0, size_ff});
   assign pc_ok  = !pc_ff[31] && (pc_ff < {19'd0, size_ff});
   assign phys_pc  = Aw'({20'd0, base_ff} + pc_ff);
   assign phys_off = Aw'({20'd0, base_ff} + off);

   // status to controller
   always_comb begin
      stat.is_run       = (kind_ff == tcse_pkg::KIND_RUN);
      stat.quantum_done = (cnt_ff == quant_ff);
      stat.fetch_fault  = !pc_ok;
      stat.need_mem     = 1'b0;
      stat.stop         = 1'b0;
      stat.stop_code    = tcse_pkg::CODE_NONE;
      case (op)
         tcse_pkg::OP_HALT: begin
            stat.stop = 1'b1; stat.stop_code = tcse_pkg::CODE_HALT;
         end
         tcse_pkg::OP_SYSC: begin
            stat.stop = 1'b1; stat.stop_code = tcse_pkg::CODE_SYSC;
         end
         tcse_pkg::OP_LOAD, tcse_pkg::OP_STORE: begin
            if (off_ok) stat.need_mem = 1'b1;
            else begin
               stat.stop = 1'b1; stat.stop_code = tcse_pkg::CODE_SEGV;
            end
         end
         tcse_pkg::OP_ADD, tcse_pkg::OP_SUB, tcse_pkg::OP_CMP, tcse_pkg::OP_IFGT,
         tcse_pkg::OP_NOP, tcse_pkg::OP_JUMP: ;
         default: begin
            stat.stop = 1'b1; stat.stop_code = tcse_pkg::CODE_ILL;
         end
      endcase
   end

   // memory port: one address per cycle, registered read
   always_ff @(posedge clock) begin
      if (ctrl.do_simple && kind_ff == tcse_pkg::KIND_WMEM)
         mem[addr_ff[Aw-1:0]] <= data_ff;
      else if (ctrl.exec && op == tcse_pkg::OP_STORE && off_ok)
         mem[phys_off] <= vi;
      if (ctrl.fetch)
         mem_q <= mem[phys_pc];
      else if (ctrl.exec)
         mem_q <= mem[phys_off];
      else if (ctrl.do_simple)
         mem_q <= mem[addr_ff[Aw-1:0]];
   end

   // request latch
   always_ff @(posedge clock) begin
      if (ctrl.take_req) begin
         kind_ff <= req_kind;
         addr_ff <= req_address;
         ridx_ff <= req_reg_index;
         data_ff <= req_data;
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < tcse_pkg::NumRegs; k++) regs_ff[k] <= '0;
         pc_ff     <= '0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         base_ff   <= '0;
         size_ff   <= 13'd4096;
         quant_ff  <= 8'd16;
         rd_ff     <= '0;
         rd_mem_ff <= 1'b0;
         ldv_ff    <= 1'b0;
         ldok_ff   <= 1'b0;
      end else begin
         if (cfg_we) begin
            case (cfg_idx)
               tcse_pkg::CSR_BASE:    base_ff  <= cfg_wdata[11:0];
               tcse_pkg::CSR_SIZE:    size_ff  <= cfg_wdata[12:0];
               tcse_pkg::CSR_QUANTUM: quant_ff <= cfg_wdata[7:0];
               default: ;
            endcase
         end
         if (ctrl.do_simple) begin
            case (kind_ff)
               tcse_pkg::KIND_RMEM: begin
                  rd_ff     <= '0;
                  rd_mem_ff <= 1'b1;
               end
               tcse_pkg::KIND_WREG: begin
                  rd_ff     <= '0;
                  rd_mem_ff <= 1'b0;
                  if (ridx_ff == tcse_pkg::RIDX_PC) pc_ff <= data_ff;
                  else if (ridx_ff == tcse_pkg::RIDX_ACC) acc_ff <= data_ff;
                  else if (ridx_ff < 4'(tcse_pkg::NumRegs))
                     regs_ff[ridx_ff[Rw-1:0]] <= data_ff;
               end
               tcse_pkg::KIND_RREG: begin
                  rd_mem_ff <= 1'b0;
                  if (ridx_ff == tcse_pkg::RIDX_PC) rd_ff <= pc_ff;
                  else if (ridx_ff == tcse_pkg::RIDX_ACC) rd_ff <= acc_ff;
                  else if (ridx_ff < 4'(tcse_pkg::NumRegs))
                     rd_ff <= regs_ff[ridx_ff[Rw-1:0]];
                  else rd_ff <= '0;
               end
               default: begin
                  rd_ff     <= '0;
                  rd_mem_ff <= 1'b0;
               end
            endcase
         end
         if (ctrl.slice_init) begin
            cnt_ff    <= '0;
            rd_ff     <= '0;
            rd_mem_ff <= 1'b0;
         end
         if (ctrl.exec) begin
            cnt_ff <= cnt_ff + 8'd1;
            case (op)
               tcse_pkg::OP_ADD: begin
                  if (ri_ok) regs_ff[ri[Rw-1:0]] <= sum;
                  acc_ff <= ri_ok ? sum : off;
                  pc_ff  <= pc_ff + 32'd1;
               end
               tcse_pkg::OP_SUB: begin
                  if (ri_ok) regs_ff[ri[Rw-1:0]] <= diff;
                  acc_ff <= diff;
                  pc_ff  <= pc_ff + 32'd1;
               end
               tcse_pkg::OP_CMP: begin
                  acc_ff <= diff;
                  pc_ff  <= pc_ff + 32'd1;
               end
               tcse_pkg::OP_IFGT:
                  pc_ff <= (!acc_ff[31] && acc_ff != 32'd0) ? arg : pc_ff + 32'd1;
               tcse_pkg::OP_NOP:  pc_ff <= pc_ff + 32'd1;
               tcse_pkg::OP_JUMP: pc_ff <= arg;
               tcse_pkg::OP_SYSC: pc_ff <= pc_ff + 32'd1;
               tcse_pkg::OP_LOAD: begin
                  acc_ff  <= off;
                  ldi_ff  <= ri[Rw-1:0];
                  ldv_ff  <= 1'b1;
                  ldok_ff <= ri_ok;
                  if (off_ok) pc_ff <= pc_ff + 32'd1;
               end
               tcse_pkg::OP_STORE: begin
                  acc_ff <= off_ok ? vi : off;
                  ldv_ff <= 1'b0;
                  if (off_ok) pc_ff <= pc_ff + 32'd1;
               end
               default: ;
            endcase
         end
         // load completes with the registered read word
         if (ctrl.mem_fin && ldv_ff) begin
            acc_ff <= mem_q;
            if (ldok_ff) regs_ff[ldi_ff] <= mem_q;
         end
      end
   end

   assign read_data = rd_mem_ff ? mem_q : rd_ff;
   assign pc_value  = pc_ff;
   assign acc_value = acc_ff;

   always_comb begin
      case (cfg_idx)
         tcse_pkg::CSR_BASE:    cfg_rdata = {20'd0, base_ff};
         tcse_pkg::CSR_SIZE:    cfg_rdata = {19'd0, size_ff};
         tcse_pkg::CSR_QUANTUM: cfg_rdata = {24'd0, quant_ff};
         default:               cfg_rdata = '0;
      endcase
   end
endmodule
`default_nettype wire

>>> rtl/teaching_cpu_slice_executor.sv
// ----------------------------------------------------------------------------
// teaching_cpu_slice_executor
// Accumulator CPU that serves memory/register requests and runs time slices.
// ----------------------------------------------------------------------------
// Memory/register requests pass decode, wait and done states to the response
// register. A run slice fetches and executes instructions, with a memory step
// per in-segment load/store, until the quantum expires, a fetch faults or an
// instruction ends it (the single memory port carries fetch and data in turn).
// One request in flight; the next is taken while a response waits.
// Synchronous active-high reset clears registers, PC, accumulator, resets config.
`default_nettype none
module teaching_cpu_slice_executor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: address[11:0], reg_index[15:12], data[47:16]
   input  wire logic [47:0] req_tdata,
   // tuser: kind[2:0]
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: read_data[31:0], pc_value[63:32], acc_value[95:64]
   output logic [95:0]      rsp_tdata,
   // tuser: interrupt_code[2:0]
   output logic [2:0]       rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   tcse_pkg::ctrl_type ctrl;
   tcse_pkg::stat_type stat;
   logic [2:0]  code;
   logic [31:0] rdat, pcv, accv;
   logic        vld_ff;
   logic [95:0] dat_ff;
   logic [2:0]  usr_ff;

   assign csr_pready = 1'b1;

   tcse_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_tvalid), .req_ready(req_tready),
      .rsp_busy(vld_ff && !rsp_tready), .ctrl(ctrl), .stat(stat), .code(code)
   );

   tcse_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_kind(req_tuser), .req_address(req_tdata[11:0]),
      .req_reg_index(req_tdata[15:12]), .req_data(req_tdata[47:16]),
      .cfg_we(csr_psel && csr_penable && csr_pwrite && csr_pready),
      .cfg_idx(csr_paddr[3:2]), .cfg_wdata(csr_pwdata), .cfg_rdata(csr_prdata),
      .read_data(rdat), .pc_value(pcv), .acc_value(accv)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (ctrl.finish) vld_ff <= 1'b1;
      else if (rsp_tready) vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         dat_ff <= {accv, pcv, rdat};
         usr_ff <= code;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = dat_ff;
   assign rsp_tuser  = usr_ff;
endmodule
`default_nettype wire
